>>> hw/rtl/ihcf_pkg.sv
// shared constants, types and checksum helper for the ipv4 header check block
`timescale 1ns / 1ps
`default_nettype none

package ihcf_pkg;

  // header geometry
  localparam int HEADER_BYTES = 20;
  localparam int IDX_W        = 5;

  localparam logic [IDX_W-1:0] TTL_IDX        = IDX_W'(8);
  localparam logic [IDX_W-1:0] PROTO_IDX      = IDX_W'(9);
  localparam logic [IDX_W-1:0] CSUM_LO_IDX    = IDX_W'(11);
  localparam logic [IDX_W-1:0] DEST_FIRST_IDX = IDX_W'(16);
  localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(HEADER_BYTES - 1);
  localparam logic [IDX_W-1:0] END_COUNT      = IDX_W'(HEADER_BYTES);

  // configuration register indexes
  localparam logic CFG_LOCAL_ADDRESS    = 1'b0;
  localparam logic CFG_ROUTING_PROTOCOL = 1'b1;

  localparam logic [7:0] DEFAULT_ROUTING_PROTOCOL = 8'd200;

  // ones-complement subtraction of 0x0100 is addition of its complement
  localparam logic [15:0] TTL_STEP_COMPLEMENT = 16'hFEFF;

  // verdict codes
  localparam logic [2:0] V_DROP    = 3'd0;
  localparam logic [2:0] V_ROUTING = 3'd1;
  localparam logic [2:0] V_LOCAL   = 3'd2;
  localparam logic [2:0] V_EXPIRED = 3'd3;
  localparam logic [2:0] V_FORWARD = 3'd4;

  // one header byte handed to the checksum accumulator
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       odd;
    logic       csum_word;
    logic [7:0] data;
  } csum_step_t;

  // end-around-carry add of two 16-bit words
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t > 17'h0FFFF) begin
      t = t - 17'h0FFFF;
    end
    return t[15:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ihcf_csum.sv
// running ones-complement header sum, fed one byte per clock while step.valid is high
`timescale 1ns / 1ps
`default_nettype none

module ihcf_csum (
  input  wire logic                clk,
  input  wire ihcf_pkg::csum_step_t step,
  output logic [15:0]              sum,
  output logic [15:0]              received
);
  import ihcf_pkg::*;

  logic [7:0]  held_byte;
  logic [15:0] word;

  assign word = {held_byte, step.data};

  // high byte is held, low byte completes the word and folds it in; the checksum word is kept as received instead
  always_ff @(posedge clk) begin
    if (step.valid) begin
      if (step.first) begin
        sum       <= '0;
        received  <= '0;
        held_byte <= step.data;
      end else if (!step.odd) begin
        held_byte <= step.data;
      end else if (step.csum_word) begin
        received <= word;
      end else begin
        sum <= oc_add(sum, word);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ipv4_header_check_forward.sv
// top level: ipv4 header byte stream in, one forwarding verdict per complete header out
`timescale 1ns / 1ps
`default_nettype none

// Takes an IPv4 header one byte per clock (start high, busy is always low), with
// first_byte marking the opening byte; a new first_byte drops any partial header.
// The checksum is accumulated a byte at a time as bytes arrive. After the
// twentieth byte the end-of-header flag fin is registered, then done and the
// result registers; done stays high for one clock and the result holds until
// the next header ends. The receiver cannot stall, and a new header may begin
// on the very next clock. Configuration writes take effect at once and are meant
// for times when no header is in flight.
module ipv4_header_check_forward (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  header_byte,
  input  wire logic        first_byte,
  input  wire logic        link_is_up,
  input  wire logic        write_enable,
  input  wire logic        write_index,
  input  wire logic [31:0] write_data,
  output logic             done,
  output logic [2:0]       verdict,
  output logic [5:0]       payload_offset,
  output logic [31:0]      destination,
  output logic [7:0]       new_ttl,
  output logic [15:0]      new_checksum,
  output logic [7:0]       protocol_number
);
  import ihcf_pkg::*;

  logic [31:0]      local_address;
  logic [7:0]       routing_protocol;
  logic [IDX_W-1:0] byte_count;
  logic [7:0]       captured_ttl;
  logic [7:0]       captured_protocol;
  logic [31:0]      captured_destination;
  logic [3:0]       captured_length;
  logic             captured_link;
  logic             fin;

  logic             take;
  logic [IDX_W-1:0] idx;
  csum_step_t       step;
  logic [15:0]      sum;
  logic [15:0]      received;
  logic [2:0]       verdict_next;
  logic [15:0]      fwd_sum;

  assign busy = 1'b0;

  // byte position and whether this request belongs to an open header
  assign idx  = first_byte ? '0 : byte_count;
  assign take = start && (first_byte || (byte_count != '0 && byte_count < END_COUNT));

  assign step.valid     = take;
  assign step.first     = first_byte;
  assign step.odd       = idx[0];
  assign step.csum_word = (idx == CSUM_LO_IDX);
  assign step.data      = header_byte;

  ihcf_csum u_csum (
    .clk      (clk),
    .step     (step),
    .sum      (sum),
    .received (received)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address    <= '0;
      routing_protocol <= DEFAULT_ROUTING_PROTOCOL;
    end else if (write_enable) begin
      unique case (write_index)
        CFG_LOCAL_ADDRESS:    local_address    <= write_data;
        CFG_ROUTING_PROTOCOL: routing_protocol <= write_data[7:0];
        default:              local_address    <= local_address;
      endcase
    end
  end

  // byte counter and end-of-header flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      fin        <= 1'b0;
    end else begin
      fin <= take && (idx == LAST_IDX);
      if (take) begin
        byte_count <= idx + IDX_W'(1);
      end
    end
  end

  // header field capture
  always_ff @(posedge clk) begin
    if (take) begin
      if (first_byte) begin
        captured_length <= header_byte[3:0];
        captured_link   <= link_is_up;
      end
      if (idx == TTL_IDX) begin
        captured_ttl <= header_byte;
      end
      if (idx == PROTO_IDX) begin
        captured_protocol <= header_byte;
      end
      if (idx >= DEST_FIRST_IDX) begin
        captured_destination <= {captured_destination[23:0], header_byte};
      end
    end
  end

  // verdict decision from the completed sum and captured fields
  assign fwd_sum = ~oc_add(sum, TTL_STEP_COMPLEMENT);

  always_comb begin
    priority if (~sum != received) begin
      verdict_next = V_DROP;
    end else if (captured_protocol == routing_protocol) begin
      verdict_next = captured_link ? V_ROUTING : V_DROP;
    end else if (captured_destination == local_address) begin
      verdict_next = V_LOCAL;
    end else if (captured_ttl <= 8'd1) begin
      verdict_next = V_EXPIRED;
    end else begin
      verdict_next = V_FORWARD;
    end
  end

  // result register, one strobe per completed header
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      verdict         <= verdict_next;
      payload_offset  <= {captured_length, 2'b00};
      destination     <= captured_destination;
      protocol_number <= captured_protocol;
      new_ttl         <= (verdict_next == V_FORWARD) ? captured_ttl - 8'd1 : 8'd0;
      new_checksum    <= (verdict_next == V_FORWARD) ? fwd_sum : 16'd0;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) byte_count <= END_COUNT)
    else $error("byte counter ran past the header length");

  assert property (@(posedge clk) disable iff (rst)
    take && idx == LAST_IDX |-> ##2 done)
    else $error("last header byte gave no result");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(fin) && $past(take, 2))
    else $error("result without a completed header");

  assert property (@(posedge clk) disable iff (rst)
    done && verdict != V_FORWARD |-> new_ttl == 8'd0 && new_checksum == 16'd0)
    else $error("forward fields set on a non-forward verdict");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the ipv4 header check and forward block
`timescale 1ns / 1ps

module testbench;
  import ihcf_pkg::*;

  typedef logic [7:0] hdr_t [HEADER_BYTES];

  typedef enum logic [1:0] {CS_GOOD, CS_FLIP, CS_FIXED} csum_mode_t;

  // one directed header: stray bytes around it, how much of it is sent, its fields
  typedef struct packed {
    logic [2:0]  noise;
    logic [4:0]  cut;
    logic [2:0]  trail;
    logic [7:0]  vihl;
    logic [7:0]  fill;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] dest;
    csum_mode_t  mode;
    logic [15:0] fixed_csum;
    logic        link;
    logic        want_known;
    logic [2:0]  want;
  } dir_row_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [5:0]  offset;
    logic [31:0] dest;
    logic [7:0]  ttl;
    logic [15:0] csum;
    logic [7:0]  proto;
  } verdict_t;

  localparam int N_PLAN = 14;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  header_byte;
  logic        first_byte;
  logic        link_is_up;
  logic        write_enable;
  logic        write_index;
  logic [31:0] write_data;
  logic        done;
  logic [2:0]  verdict;
  logic [5:0]  payload_offset;
  logic [31:0] destination;
  logic [7:0]  new_ttl;
  logic [15:0] new_checksum;
  logic [7:0]  protocol_number;

  // predictor copy of the configuration and header capture state
  logic [31:0] cfg_local;
  logic [7:0]  cfg_routing;
  logic [4:0]  pos_count;
  logic [7:0]  held;
  logic [15:0] sum;
  logic [15:0] rx_csum;
  logic [7:0]  cap_ttl;
  logic [7:0]  cap_proto;
  logic [31:0] cap_dest;
  logic [3:0]  cap_len;
  logic        cap_link;

  verdict_t    pending_verdicts[$];
  dir_row_t    plan [N_PLAN];
  int          error_count = 0;
  int          bytes_taken = 0;
  int          results_checked = 0;
  int          verdict_tally [5];
  bit          gaps_on;

  ipv4_header_check_forward uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .header_byte     (header_byte),
    .first_byte      (first_byte),
    .link_is_up      (link_is_up),
    .write_enable    (write_enable),
    .write_index     (write_index),
    .write_data      (write_data),
    .done            (done),
    .verdict         (verdict),
    .payload_offset  (payload_offset),
    .destination     (destination),
    .new_ttl         (new_ttl),
    .new_checksum    (new_checksum),
    .protocol_number (protocol_number)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ones-complement add with end-around carry
  function automatic logic [15:0] end_around(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = a + b;
    return t[15:0] + t[16];
  endfunction

  // fills in the checksum word so the header verifies
  function automatic hdr_t with_checksum(input hdr_t h);
    logic [15:0] acc;
    acc = 16'h0;
    for (int i = 0; i < HEADER_BYTES; i += 2) begin
      if (i != 10) begin
        acc = end_around(acc, {h[i], h[i+1]});
      end
    end
    h[10] = ~acc[15:8];
    h[11] = ~acc[7:0];
    return h;
  endfunction

  // predictor: one accepted byte request, queues a verdict after the last byte
  task automatic take_byte(input logic [7:0] b, input logic f, input logic l);
    logic [4:0] pos;
    verdict_t   r;
    if (f) begin
      pos = 5'd0;
      sum = 16'h0;
      rx_csum = 16'h0;
      cap_ttl = 8'h0;
      cap_proto = 8'h0;
      cap_dest = 32'h0;
      cap_len = b[3:0];
      cap_link = l;
    end else begin
      if (pos_count == 5'd0 || pos_count >= END_COUNT) begin
        return;
      end
      pos = pos_count;
    end
    if (!pos[0]) begin
      held = b;
    end else if (pos == CSUM_LO_IDX) begin
      rx_csum = {held, b};
    end else begin
      sum = end_around(sum, {held, b});
    end
    if (pos == TTL_IDX) begin
      cap_ttl = b;
    end else if (pos == PROTO_IDX) begin
      cap_proto = b;
    end else if (pos >= DEST_FIRST_IDX) begin
      cap_dest = {cap_dest[23:0], b};
    end
    pos_count = pos + 5'd1;
    if (pos != LAST_IDX) begin
      return;
    end
    r = '0;
    if (~sum != rx_csum) begin
      r.verdict = V_DROP;
    end else if (cap_proto == cfg_routing) begin
      r.verdict = cap_link ? V_ROUTING : V_DROP;
    end else if (cap_dest == cfg_local) begin
      r.verdict = V_LOCAL;
    end else if (cap_ttl <= 8'd1) begin
      r.verdict = V_EXPIRED;
    end else begin
      r.verdict = V_FORWARD;
      r.ttl = cap_ttl - 8'd1;
      r.csum = ~end_around(sum, TTL_STEP_COMPLEMENT);
    end
    r.offset = {cap_len, 2'b00};
    r.dest = cap_dest;
    r.proto = cap_proto;
    pending_verdicts.push_back(r);
  endtask

  // one byte request, with a random gap ahead of it when gaps are on
  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    if (gaps_on && $urandom_range(99) < 5) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    header_byte <= b;
    first_byte <= f;
    link_is_up <= l;
    do @(posedge clk); while (busy);
    bytes_taken++;
    take_byte(b, f, l);
  endtask

  // link only counts on the opening byte, so later bytes carry noise there
  task automatic send_header(input hdr_t h, input int count, input logic link);
    for (int i = 0; i < count; i++) begin
      send_byte(h[i], i == 0, (i == 0) ? link : 1'($urandom_range(1)));
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
  endtask

  // drain outstanding verdicts, then let any partial header settle
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, written back to back on the idle block
  task automatic write_config(input logic [31:0] addr, input logic [7:0] proto);
    write_enable <= 1'b1;
    write_index <= CFG_LOCAL_ADDRESS;
    write_data <= addr;
    @(posedge clk);
    write_index <= CFG_ROUTING_PROTOCOL;
    write_data <= {24'h0, proto};
    @(posedge clk);
    write_enable <= 1'b0;
    cfg_local = addr;
    cfg_routing = proto;
  endtask

  // well-formed headers mostly, with fields steered toward every verdict
  function automatic hdr_t random_header();
    hdr_t        h;
    logic [15:0] c;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      h[i] = 8'($urandom_range(255));
    end
    if ($urandom_range(1)) begin
      h[0] = 8'h45;
    end
    case ($urandom_range(7))
      0: h[8] = 8'd0;
      1: h[8] = 8'd1;
      2: h[8] = 8'd2;
      3: h[8] = 8'd255;
      default: ;
    endcase
    if ($urandom_range(9) < 3) begin
      h[9] = cfg_routing;
    end
    if ($urandom_range(9) < 3) begin
      {h[16], h[17], h[18], h[19]} = cfg_local;
    end
    h = with_checksum(h);
    if ($urandom_range(99) < 15) begin
      c = {h[10], h[11]} ^ (16'h1 << $urandom_range(15));
      h[10] = c[15:8];
      h[11] = c[7:0];
    end
    return h;
  endfunction

  task automatic run_phase(input logic [31:0] addr, input logic [7:0] proto,
                           input bit gaps, input int byte_budget);
    int   stop_at;
    int   pick;
    hdr_t h;
    wait_idle();
    write_config(addr, proto);
    gaps_on = gaps;
    stop_at = bytes_taken + byte_budget;
    while (bytes_taken < stop_at) begin
      pick = $urandom_range(99);
      h = random_header();
      if (pick < 6) begin
        send_noise($urandom_range(1, 4));
      end else if (pick < 12) begin
        // broken header, the next opening byte discards it
        send_header(h, $urandom_range(1, HEADER_BYTES - 1), 1'($urandom_range(1)));
      end else begin
        send_header(h, HEADER_BYTES, 1'($urandom_range(1)));
        if ($urandom_range(9) == 0) begin
          send_noise($urandom_range(1, 3));
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // result checker, done cannot be held off
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && done === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict with no header pending");
      end else begin
        want = pending_verdicts.pop_front();
        compare_field("verdict", verdict, want.verdict);
        compare_field("payload_offset", payload_offset, want.offset);
        compare_field("destination", destination, want.dest);
        compare_field("new_ttl", new_ttl, want.ttl);
        compare_field("new_checksum", new_checksum, want.csum);
        compare_field("protocol_number", protocol_number, want.proto);
        results_checked++;
        if (want.verdict <= V_FORWARD) begin
          verdict_tally[want.verdict]++;
        end
      end
    end
  end

  // stimulus
  initial begin
    hdr_t     h;
    verdict_t last;
    rst <= 1'b1;
    start <= 1'b0;
    header_byte <= 8'h0;
    first_byte <= 1'b0;
    link_is_up <= 1'b0;
    write_enable <= 1'b0;
    write_index <= CFG_LOCAL_ADDRESS;
    write_data <= 32'h0;
    cfg_local = 32'h0;
    cfg_routing = DEFAULT_ROUTING_PROTOCOL;
    pos_count = 5'd0;
    held = 8'h0;
    sum = 16'h0;
    rx_csum = 16'h0;
    cap_ttl = 8'h0;
    cap_proto = 8'h0;
    cap_dest = 32'h0;
    cap_len = 4'h0;
    cap_link = 1'b0;
    foreach (verdict_tally[i]) verdict_tally[i] = 0;

    // directed headers, run on the reset configuration
    plan = '{
      // stray bytes right after reset are ignored
      '{3'd3, 5'd20, 3'd0, 8'h45, 8'h00, 8'd64, 8'd6, 32'hC0A80001, CS_GOOD,
        16'h0, 1'b1, 1'b1, V_FORWARD},
      // all-zero header: checksum ffff verifies, zero does not
      '{3'd0, 5'd20, 3'd0, 8'h00, 8'h00, 8'd0, 8'd0, 32'h0, CS_FIXED,
        16'hFFFF, 1'b1, 1'b1, V_LOCAL},
      '{3'd0, 5'd20, 3'd0, 8'h00, 8'h00, 8'd0, 8'd0, 32'h0, CS_FIXED,
        16'h0000, 1'b1, 1'b1, V_DROP},
      '{3'd0, 5'd20, 3'd0, 8'h45, 8'h5A, 8'd64, 8'd6, 32'hC0A80001, CS_FLIP,
        16'h0, 1'b1, 1'b1, V_DROP},
      // routing protocol, link up then down
      '{3'd0, 5'd20, 3'd0, 8'h45, 8'h11, 8'd64, DEFAULT_ROUTING_PROTOCOL,
        32'h0A0A0A0A, CS_GOOD, 16'h0, 1'b1, 1'b1, V_ROUTING},
      '{3'd0, 5'd20, 3'd0, 8'h45, 8'h11, 8'd64, DEFAULT_ROUTING_PROTOCOL,
        32'h0A0A0A0A, CS_GOOD, 16'h0, 1'b0, 1'b1, V_DROP},
      // ttl at and around the expiry edge
      '{3'd0, 5'd20, 3'd0, 8'h45, 8'h22, 8'd0, 8'd17, 32'h0A0A0A0B, CS_GOOD,
        16'h0, 1'b1, 1'b1, V_EXPIRED},
      '{3'd0, 5'd20, 3'd0, 8'h45, 8'h22, 8'd1, 8'd17, 32'h0A0A0A0B, CS_GOOD,
        16'h0, 1'b0, 1'b1, V_EXPIRED},
      '{3'd0, 5'd20, 3'd0, 8'h45, 8'h22, 8'd2, 8'd17, 32'h0A0A0A0B, CS_GOOD,
        16'h0, 1'b1, 1'b1, V_FORWARD},
      // all ones
      '{3'd0, 5'd20, 3'd0, 8'hFF, 8'hFF, 8'd255, 8'd255, 32'hFFFFFFFF, CS_GOOD,
        16'h0, 1'b1, 1'b1, V_FORWARD},
      // cut short, the next header restarts mid-way
      '{3'd0, 5'd11, 3'd0, 8'h46, 8'h33, 8'd9, 8'd6, 32'h01020304, CS_GOOD,
        16'h0, 1'b1, 1'b0, V_DROP},
      // bytes past a complete header are ignored
      '{3'd0, 5'd20, 3'd4, 8'h4F, 8'hA5, 8'd128, 8'd17, 32'h08080808, CS_GOOD,
        16'h0, 1'b0, 1'b1, V_FORWARD},
      // routing wins over local, local wins over expiry
      '{3'd0, 5'd20, 3'd0, 8'h45, 8'h00, 8'd64, DEFAULT_ROUTING_PROTOCOL, 32'h0,
        CS_GOOD, 16'h0, 1'b1, 1'b1, V_ROUTING},
      '{3'd0, 5'd20, 3'd0, 8'h45, 8'h00, 8'd0, 8'd1, 32'h0, CS_GOOD,
        16'h0, 1'b1, 1'b1, V_LOCAL}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gaps_on = 1'b1;
    for (int r = 0; r < N_PLAN; r++) begin
      send_noise(plan[r].noise);
      foreach (h[i]) h[i] = plan[r].fill;
      h[0] = plan[r].vihl;
      h[8] = plan[r].ttl;
      h[9] = plan[r].proto;
      {h[16], h[17], h[18], h[19]} = plan[r].dest;
      h = with_checksum(h);
      case (plan[r].mode)
        CS_FLIP: h[11] = h[11] ^ 8'h01;
        CS_FIXED: begin
          h[10] = plan[r].fixed_csum[15:8];
          h[11] = plan[r].fixed_csum[7:0];
        end
        default: ;
      endcase
      send_header(h, plan[r].cut, plan[r].link);
      // typed verdict stands in for the predicted one
      if (plan[r].want_known && plan[r].cut == HEADER_BYTES &&
          pending_verdicts.size() != 0) begin
        last = pending_verdicts.pop_back();
        last.verdict = plan[r].want;
        pending_verdicts.push_back(last);
      end
      send_noise(plan[r].trail);
    end

    // random headers under several configurations, one phase without gaps
    run_phase(32'hFFFFFFFF, 8'd0, 1'b1, 220);
    run_phase(32'h0A000001, 8'd255, 1'b0, 220);
    run_phase($urandom, DEFAULT_ROUTING_PROTOCOL, 1'b1, 220);
    run_phase($urandom, 8'($urandom_range(255)), 1'b1, 220);
    run_phase(32'h0, 8'($urandom_range(255)), 1'b1, 220);

    wait_idle();
    repeat (8) @(posedge clk);

    $display("sent %0d header bytes, checked %0d verdicts", bytes_taken, results_checked);
    $display("drop %0d, routing %0d, local %0d, expired %0d, forward %0d",
             verdict_tally[V_DROP], verdict_tally[V_ROUTING], verdict_tally[V_LOCAL],
             verdict_tally[V_EXPIRED], verdict_tally[V_FORWARD]);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
